// ===== rtl/core/pidmt_pkg.sv =====
// shared types and constants of the protected identifier membership table
// depends on nothing; used by every module of the block but pidmt_ram, by scoped names
package pidmt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PID_W       = 22;

    // stream widths
    localparam int ACT_W       = 2;
    localparam int STAT_W      = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 8;

    // request kinds
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    // result codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PRESENT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ABSENT  = 2'd3;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // outcome of comparing one table entry against the key
    typedef struct packed {
        logic hit;
        logic free;
    } match_t;

endpackage

// ===== rtl/core/pidmt_ram.sv =====
// generic single-write, single-read ram with registered read data
// depends on nothing
module pidmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pidmt_match.sv =====
// compare unit shared by every step of the table scan
// depends on pidmt_pkg
module pidmt_match (
    input  logic                    entry_valid,
    input  logic [pidmt_pkg::PID_W-1:0] entry_id,
    input  logic [pidmt_pkg::PID_W-1:0] key,
    output pidmt_pkg::match_t       result
);

    // only valid entries can match, free slots are reported apart
    always_comb begin
        result.hit  = entry_valid && (entry_id == key);
        result.free = !entry_valid;
    end

endmodule

// ===== rtl/core/pidmt_ctrl.sv =====
// scan sequencer, valid marks, enable register and result register
// depends on pidmt_pkg
module pidmt_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request side
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [pidmt_pkg::ACT_W-1:0]   req_action,
    input  logic [pidmt_pkg::PID_W-1:0]   req_pid,
    // result side
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [pidmt_pkg::STAT_W-1:0]  rsp_status,
    output logic                          rsp_prot,
    // enable register write
    input  logic                          cfg_we,
    input  logic                          cfg_bit,
    // table ram
    output logic                          ram_we,
    output logic [pidmt_pkg::IDX_W-1:0]   ram_waddr,
    output logic [pidmt_pkg::PID_W-1:0]   ram_wdata,
    output logic [pidmt_pkg::IDX_W-1:0]   ram_raddr,
    // compare unit
    output logic                          cmp_entry_valid,
    output logic [pidmt_pkg::PID_W-1:0]   cmp_key,
    input  pidmt_pkg::match_t             cmp_result
);

    localparam int DEPTH = pidmt_pkg::TABLE_DEPTH;
    localparam int IDX_W = pidmt_pkg::IDX_W;
    localparam int CNT_W = pidmt_pkg::CNT_W;

    pidmt_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]                rd_idx_reg, rd_idx_next;
    logic                            cmp_pend_reg, cmp_pend_next;
    logic [IDX_W-1:0]                cmp_idx_reg, cmp_idx_next;
    logic [pidmt_pkg::ACT_W-1:0]     act_reg, act_next;
    logic [pidmt_pkg::PID_W-1:0]     pid_reg, pid_next;
    logic                            hit_reg, hit_next;
    logic [IDX_W-1:0]                hit_idx_reg, hit_idx_next;
    logic                            free_found_reg, free_found_next;
    logic [IDX_W-1:0]                free_idx_reg, free_idx_next;
    logic [DEPTH-1:0]                valid_reg, valid_next;
    logic                            enable_reg, enable_next;
    logic                            out_valid_reg, out_valid_next;
    logic [pidmt_pkg::STAT_W-1:0]    status_reg, status_next;
    logic                            prot_reg, prot_next;

    logic accept;
    logic issue;
    logic last_cmp;
    logic commit;

    // handshake and scan conditions
    assign req_ready = (state_reg == pidmt_pkg::S_IDLE);
    assign accept    = req_valid && req_ready;
    assign issue     = (rd_idx_reg < CNT_W'(DEPTH));
    assign last_cmp  = cmp_pend_reg && (cmp_idx_reg == IDX_W'(DEPTH - 1));
    assign commit    = (state_reg == pidmt_pkg::S_FINISH) && (!out_valid_reg || rsp_ready);

    // compare unit hookup
    assign cmp_entry_valid = valid_reg[cmp_idx_reg];
    assign cmp_key         = pid_reg;
    assign ram_raddr       = rd_idx_reg[IDX_W-1:0];

    // new identifier goes to the lowest free slot
    assign ram_we    = commit && (act_reg == pidmt_pkg::ACT_ADD) && !hit_reg && free_found_reg;
    assign ram_waddr = free_idx_reg;
    assign ram_wdata = pid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pidmt_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = pidmt_pkg::S_SCAN;
                end
            end
            pidmt_pkg::S_SCAN: begin
                if (cmp_pend_reg && (cmp_result.hit || last_cmp)) begin
                    state_next = pidmt_pkg::S_FINISH;
                end
            end
            pidmt_pkg::S_FINISH: begin
                if (commit) begin
                    state_next = pidmt_pkg::S_IDLE;
                end
            end
            default: state_next = pidmt_pkg::S_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        rd_idx_next     = rd_idx_reg;
        cmp_pend_next   = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        act_next        = act_reg;
        pid_next        = pid_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        enable_next     = cfg_we ? cfg_bit : enable_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        status_next     = status_reg;
        prot_next       = prot_reg;

        case (state_reg)
            // latch the request and restart the scan
            pidmt_pkg::S_IDLE: begin
                if (accept) begin
                    act_next        = req_action;
                    pid_next        = req_pid;
                    rd_idx_next     = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            // one read issued and one entry compared per cycle
            pidmt_pkg::S_SCAN: begin
                if (issue) begin
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = rd_idx_reg[IDX_W-1:0];
                end
                if (cmp_pend_reg) begin
                    if (cmp_result.hit) begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                    end
                    if (cmp_result.free && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                end
            end
            // apply the table update and load the result register
            pidmt_pkg::S_FINISH: begin
                if (commit) begin
                    out_valid_next = 1'b1;
                    status_next    = pidmt_pkg::STAT_OK;
                    prot_next      = 1'b0;
                    case (act_reg)
                        pidmt_pkg::ACT_ADD: begin
                            if (hit_reg) begin
                                status_next = pidmt_pkg::STAT_PRESENT;
                            end else if (!free_found_reg) begin
                                status_next = pidmt_pkg::STAT_FULL;
                            end else begin
                                valid_next[free_idx_reg] = 1'b1;
                            end
                        end
                        pidmt_pkg::ACT_REMOVE: begin
                            if (hit_reg) begin
                                valid_next[hit_idx_reg] = 1'b0;
                            end else begin
                                status_next = pidmt_pkg::STAT_ABSENT;
                            end
                        end
                        pidmt_pkg::ACT_QUERY: begin
                            prot_next = enable_reg && hit_reg;
                        end
                        default: begin
                            status_next = pidmt_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            default: begin
                cmp_pend_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pidmt_pkg::S_IDLE;
            cmp_pend_reg  <= 1'b0;
            valid_reg     <= '0;
            enable_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cmp_pend_reg  <= cmp_pend_next;
            valid_reg     <= valid_next;
            enable_reg    <= enable_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        act_reg        <= act_next;
        pid_reg        <= pid_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        status_reg     <= status_next;
        prot_reg       <= prot_next;
    end

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = status_reg;
    assign rsp_prot   = prot_reg;

endmodule

// ===== rtl/core/protected_id_membership_table.sv =====
// Protected identifier membership table: a table of process identifiers
// with add, remove and query requests on a stream channel.
//
// Channels: s_* carries requests (s_tuser = kind, s_tdata = identifier),
// m_* carries one result transaction per request (status and the
// protected flag). cfg_* writes the one-bit protect enable; it is always
// ready and must only be written while no request is in flight.
// Scan: a request scans the table one entry per cycle through a single
// ram read port and compare unit. A match at slot k ends the scan there;
// a request without a match scans the whole table. s_tready is low from
// acceptance until the result is loaded, so the next request is accepted
// at the earliest in the cycle after that.
// Stall: the result sits in an output register; a new request is accepted
// while it waits, but that request's result is held back until m_tready
// frees the register.
// Reset: aresetn (synchronous, active low) clears every valid mark, the
// enable register and the output valid; no clearing pass is needed.
// depends on pidmt_pkg, pidmt_ram, pidmt_match, pidmt_ctrl
module protected_id_membership_table (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request: tdata[21:0] pid, upper bits zero
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pidmt_pkg::S_TDATA_W-1:0]    s_tdata,
    // request: tuser[1:0] action
    input  logic [pidmt_pkg::ACT_W-1:0]        s_tuser,
    // result: tdata[1:0] status, tdata[2] is_protected, upper bits zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pidmt_pkg::M_TDATA_W-1:0]    m_tdata,
    // protect_enable write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data
);

    logic                              ram_we;
    logic [pidmt_pkg::IDX_W-1:0]       ram_waddr;
    logic [pidmt_pkg::PID_W-1:0]       ram_wdata;
    logic [pidmt_pkg::IDX_W-1:0]       ram_raddr;
    logic [pidmt_pkg::PID_W-1:0]       ram_rdata;
    logic                              cmp_entry_valid;
    logic [pidmt_pkg::PID_W-1:0]       cmp_key;
    pidmt_pkg::match_t                 cmp_result;
    logic [pidmt_pkg::STAT_W-1:0]      rsp_status;
    logic                              rsp_prot;

    assign cfg_ready = 1'b1;

    // identifier store
    pidmt_ram #(
        .WIDTH (pidmt_pkg::PID_W),
        .DEPTH (pidmt_pkg::TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared compare unit
    pidmt_match u_match (
        .entry_valid (cmp_entry_valid),
        .entry_id    (ram_rdata),
        .key         (cmp_key),
        .result      (cmp_result)
    );

    // sequencer
    pidmt_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .req_valid       (s_tvalid),
        .req_ready       (s_tready),
        .req_action      (s_tuser),
        .req_pid         (s_tdata[pidmt_pkg::PID_W-1:0]),
        .rsp_valid       (m_tvalid),
        .rsp_ready       (m_tready),
        .rsp_status      (rsp_status),
        .rsp_prot        (rsp_prot),
        .cfg_we          (cfg_valid),
        .cfg_bit         (cfg_data),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_raddr       (ram_raddr),
        .cmp_entry_valid (cmp_entry_valid),
        .cmp_key         (cmp_key),
        .cmp_result      (cmp_result)
    );

    // result packing
    assign m_tdata = {
        (pidmt_pkg::M_TDATA_W - pidmt_pkg::STAT_W - 1)'(0),
        rsp_prot,
        rsp_status
    };

endmodule

// ===== rtl/core/pidmt_chk.sv =====
// port-level checks of the protected identifier membership table
// depends on pidmt_pkg; bound to protected_id_membership_table
module pidmt_chk (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [pidmt_pkg::M_TDATA_W-1:0]  m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time: busy after each accepted transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken during a scan");

    // a new result only appears as a scan ends
    a_rsp_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready) && s_tready)
        else $error("result without a finished scan");

    // protected flag only with status ok
    a_prot_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[1:0] == pidmt_pkg::STAT_OK)
        else $error("protected flag with an error status");

endmodule

bind protected_id_membership_table pidmt_chk u_chk (.*);

// ===== tb/tb_protected_id_membership_table.sv =====
// self-checking testbench for protected_id_membership_table: add, remove, query and
// spare requests with random gaps and stalls, checked against a local table model
// depends on pidmt_pkg and the protected_id_membership_table rtl
module tb_protected_id_membership_table;
    timeunit 1ns;
    timeprecision 1ps;

    // unused request kind: ignored by the block, still answered
    localparam logic [pidmt_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;
    localparam logic [pidmt_pkg::PID_W-1:0] PID_ALL   = {pidmt_pkg::PID_W{1'b1}};
    localparam int CYCLE_LIMIT = 1500000;
    localparam int POOL_SIZE   = 96;
    localparam int DRAIN_WAIT  = pidmt_pkg::TABLE_DEPTH + 16;

    typedef struct packed {
        logic [pidmt_pkg::ACT_W-1:0] kind;
        logic [pidmt_pkg::PID_W-1:0] pid;
    } request_t;

    typedef struct packed {
        logic [pidmt_pkg::STAT_W-1:0] status;
        logic                         prot;
    } outcome_t;

    typedef struct packed {
        request_t req;
        outcome_t res;
    } pending_result_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [pidmt_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [pidmt_pkg::ACT_W-1:0]      s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [pidmt_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic                             cfg_data;

    // local copy of the table and the enable register
    logic [pidmt_pkg::PID_W-1:0]      slot_id   [pidmt_pkg::TABLE_DEPTH];
    logic                             slot_used [pidmt_pkg::TABLE_DEPTH];
    logic                             protect_on;

    request_t                         request_q[$];
    pending_result_t                  result_q[$];
    logic [pidmt_pkg::PID_W-1:0]      pid_pool[POOL_SIZE];

    int                               src_idle_pct;
    int                               snk_idle_pct;
    int                               error_count;
    int                               cycle_count;
    logic                             req_taken;

    protected_id_membership_table u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // apply one request to the local table and work out its answer
    function automatic outcome_t apply_request(request_t req);
        outcome_t res;
        int       hit;
        int       gap;
        res.status = pidmt_pkg::STAT_OK;
        res.prot   = 1'b0;
        hit        = -1;
        gap        = -1;
        for (int i = 0; i < pidmt_pkg::TABLE_DEPTH; i++) begin
            if (slot_used[i] && slot_id[i] == req.pid && hit < 0)
                hit = i;
            if (!slot_used[i] && gap < 0)
                gap = i;
        end
        case (req.kind)
            pidmt_pkg::ACT_ADD: begin
                if (hit >= 0)
                    res.status = pidmt_pkg::STAT_PRESENT;
                else if (gap < 0)
                    res.status = pidmt_pkg::STAT_FULL;
                else begin
                    slot_id[gap]   = req.pid;
                    slot_used[gap] = 1'b1;
                end
            end
            pidmt_pkg::ACT_REMOVE: begin
                if (hit < 0)
                    res.status = pidmt_pkg::STAT_ABSENT;
                else begin
                    slot_id[hit]   = '0;
                    slot_used[hit] = 1'b0;
                end
            end
            pidmt_pkg::ACT_QUERY: begin
                res.prot = protect_on && (hit >= 0);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want, request_t req);
        $display("mismatch at %0t: %s got %0d expected %0d (kind %0d pid 0x%06h)",
                 $realtime, what, got, want, req.kind, req.pid);
        error_count++;
    endtask

    task automatic push_request(logic [pidmt_pkg::ACT_W-1:0] kind,
                                logic [pidmt_pkg::PID_W-1:0] pid);
        request_t req;
        req.kind = kind;
        req.pid  = pid;
        request_q.push_back(req);
    endtask

    // random requests, kind weights in percent, the remainder is the spare kind
    task automatic queue_random(int count, int add_pct, int rem_pct, int qry_pct);
        int                          pick;
        logic [pidmt_pkg::PID_W-1:0] pid;
        logic [pidmt_pkg::ACT_W-1:0] kind;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < add_pct)
                kind = pidmt_pkg::ACT_ADD;
            else if (pick < add_pct + rem_pct)
                kind = pidmt_pkg::ACT_REMOVE;
            else if (pick < add_pct + rem_pct + qry_pct)
                kind = pidmt_pkg::ACT_QUERY;
            else
                kind = ACT_SPARE;
            // mostly a recurring pool so that hits, duplicates and a full table occur
            if ($urandom_range(99) < 75)
                pid = pid_pool[$urandom_range(POOL_SIZE - 1)];
            else
                pid = pidmt_pkg::PID_W'($urandom());
            push_request(kind, pid);
        end
    endtask

    // enable register write, only while no request is in flight
    task automatic write_enable(logic value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        protect_on = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every queued request is taken and answered
    task automatic wait_drained();
        while (request_q.size() != 0 || s_tvalid || result_q.size() != 0)
            @(negedge aclk);
    endtask

    // request driver, new transaction once the previous one was taken
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || req_taken)) begin
            if (request_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pidmt_pkg::S_TDATA_W'(request_q[0].pid);
                s_tuser  <= request_q[0].kind;
                void'(request_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result acceptance with random stalls
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= snk_idle_pct);
    end

    // monitor: check results first, then predict the request taken at this edge
    always @(posedge aclk) begin
        pending_result_t exp_item;
        request_t        req;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end else begin
            if (aresetn && m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    req = '0;
                    report_mismatch("unexpected result, status", int'(m_tdata[1:0]), 0,
                                    req);
                end else begin
                    exp_item = result_q.pop_front();
                    if (m_tdata[1:0] != exp_item.res.status)
                        report_mismatch("status", int'(m_tdata[1:0]),
                                        int'(exp_item.res.status), exp_item.req);
                    if (m_tdata[2] != exp_item.res.prot)
                        report_mismatch("is_protected", int'(m_tdata[2]),
                                        int'(exp_item.res.prot), exp_item.req);
                end
            end
            if (aresetn && s_tvalid && s_tready) begin
                exp_item.req.kind = s_tuser;
                exp_item.req.pid  = s_tdata[pidmt_pkg::PID_W-1:0];
                exp_item.res      = apply_request(exp_item.req);
                result_q.push_back(exp_item);
            end
            req_taken <= aresetn && s_tvalid && s_tready;
        end
    end

    // stimulus sequence
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = pidmt_pkg::ACT_ADD;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        req_taken    = 1'b0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        error_count  = 0;
        cycle_count  = 0;
        protect_on   = 1'b0;
        for (int i = 0; i < pidmt_pkg::TABLE_DEPTH; i++) begin
            slot_id[i]   = '0;
            slot_used[i] = 1'b0;
        end
        pid_pool[0] = '0;
        pid_pool[1] = PID_ALL;
        for (int i = 2; i < POOL_SIZE; i++)
            pid_pool[i] = pidmt_pkg::PID_W'($urandom());

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, protection off: duplicates, extremes, disabled queries
        write_enable(1'b0);
        push_request(pidmt_pkg::ACT_ADD,    '0);
        push_request(pidmt_pkg::ACT_ADD,    '0);
        push_request(pidmt_pkg::ACT_ADD,    PID_ALL);
        push_request(pidmt_pkg::ACT_ADD,    22'h155555);
        push_request(pidmt_pkg::ACT_QUERY,  '0);
        push_request(pidmt_pkg::ACT_QUERY,  PID_ALL);
        push_request(ACT_SPARE,             PID_ALL);
        push_request(pidmt_pkg::ACT_REMOVE, 22'h2AAAAA);
        push_request(pidmt_pkg::ACT_QUERY,  22'h000001);
        wait_drained();

        // directed, protection on: hits, misses, removal and slot reuse
        write_enable(1'b1);
        push_request(pidmt_pkg::ACT_QUERY,  '0);
        push_request(pidmt_pkg::ACT_QUERY,  PID_ALL);
        push_request(pidmt_pkg::ACT_QUERY,  22'h000001);
        push_request(ACT_SPARE,             '0);
        push_request(pidmt_pkg::ACT_REMOVE, '0);
        push_request(pidmt_pkg::ACT_REMOVE, '0);
        push_request(pidmt_pkg::ACT_QUERY,  '0);
        push_request(pidmt_pkg::ACT_ADD,    22'h2AAAAA);
        push_request(pidmt_pkg::ACT_ADD,    '0);
        push_request(pidmt_pkg::ACT_QUERY,  22'h2AAAAA);
        push_request(pidmt_pkg::ACT_REMOVE, PID_ALL);
        push_request(pidmt_pkg::ACT_QUERY,  PID_ALL);
        wait_drained();

        // random, add heavy so the table fills; slow receiver
        src_idle_pct = 25;
        snk_idle_pct = 87;
        queue_random(400, 60, 10, 25);
        wait_drained();

        // random, remove heavy with protection off; slow sender
        write_enable(1'b0);
        src_idle_pct = 87;
        snk_idle_pct = 25;
        queue_random(300, 15, 55, 25);
        wait_drained();

        // random, balanced, back to back
        write_enable(1'b1);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_random(400, 35, 30, 30);
        wait_drained();

        // let any stray result show up
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0 && result_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pidmt_pkg.sv
rtl/core/pidmt_ram.sv
rtl/core/pidmt_match.sv
rtl/core/pidmt_ctrl.sv
rtl/core/protected_id_membership_table.sv
rtl/core/pidmt_chk.sv
tb/tb_protected_id_membership_table.sv
